// File: hw/rtl/trq_pkg.sv
// Shared types, codes and helpers of the timed reply queue.
`default_nettype none
package trq_pkg;

    // Request kinds carried in s_tuser.
    localparam logic FUNC_QUEUE = 1'b0;
    localparam logic FUNC_POLL  = 1'b1;

    localparam int MOD_W       = 8;
    localparam int KIND_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + MOD_W + KIND_W + 1 + CNT_W);

    // Record that walks along the slot cells, one cell per cycle.
    // For a queue request module_id/kind/due are the entry to place and hit
    // means it was placed. For a poll they hold the best due entry so far.
    typedef struct packed {
        logic              active;
        logic              func;
        logic              hit;
        logic [MOD_W-1:0]  module_id;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
    } trq_scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } trq_state_t;

    // True when a - b, read as a signed 32-bit value, is negative.
    function automatic logic diff_negative(input logic [TIME_W-1:0] a,
                                           input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/trq_cell.sv
// One slot of the reply table together with its stage of the scan chain.
`default_nettype none
module trq_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  trq_pkg::trq_scan_t   scan_in,
    input  wire  [IDX_W-1:0]     idx_in,
    output trq_pkg::trq_scan_t   scan_out,
    output logic [IDX_W-1:0]     idx_out,
    input  wire                  free_en,
    input  wire  [IDX_W-1:0]     free_idx
);
    import trq_pkg::*;

    logic              used_reg;
    logic              used_next;
    logic [MOD_W-1:0]  module_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [TIME_W-1:0] due_reg;
    logic              write_en;
    trq_scan_t         scan_reg;
    trq_scan_t         scan_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    always_comb
    begin
        scan_next = scan_in;
        idx_next  = idx_in;
        write_en  = 1'b0;
        used_next = used_reg;
        if (scan_in.active)
        begin
            if (scan_in.func == FUNC_QUEUE)
            begin
                // The first free slot along the chain takes the entry.
                if (!used_reg && !scan_in.hit)
                begin
                    write_en      = 1'b1;
                    used_next     = 1'b1;
                    scan_next.hit = 1'b1;
                end
            end
            else if (used_reg && !diff_negative(scan_in.now, due_reg) &&
                     (!scan_in.hit || diff_negative(due_reg, scan_in.due)))
            begin
                // Strictly earlier only, so a tie keeps the lower slot.
                scan_next.hit       = 1'b1;
                scan_next.module_id = module_reg;
                scan_next.kind      = kind_reg;
                scan_next.due       = due_reg;
                idx_next            = IDX_W'(INDEX);
            end
        end
        if (free_en && (free_idx == IDX_W'(INDEX)))
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (write_en)
        begin
            module_reg <= scan_in.module_id;
            kind_reg   <= scan_in.kind;
            due_reg    <= scan_in.due;
        end
    end

    assign scan_out = scan_reg;
    assign idx_out  = idx_reg;

endmodule
`default_nettype wire

// File: hw/rtl/timed_reply_queue.sv
// Top level of the timed reply queue: request intake, slot chain and result register.
`default_nettype none
// The timed reply queue keeps up to QUEUE_DEPTH pending replies, each with a
// module number, a reply kind and a due time in milliseconds. A queue request
// (s_tuser = 0) stores its entry in the lowest free slot, or bumps the
// wrapping drop counter when every slot is in use. A poll request
// (s_tuser = 1) finds, among the used slots whose due time has been reached
// (now - due is not negative as a signed 32-bit value), the one with the
// earliest due time, the lowest slot winning a tie, then frees it and returns
// its module and kind. While link_enabled is zero a poll returns no reply and
// frees nothing; queue requests are stored as usual. Every request yields
// exactly one result. The slots form a chain of cells and a request record
// walks the chain one cell per clock. The record leaving the chain is
// latched in a hold register, then the result is committed to the output
// register, and only after the commit is the next request accepted. The
// block handles one request at a time; a finished result waits in the
// output register, and the next request is taken while it waits. That next
// request then waits in the hold register, and s_tready stays low, until
// the waiting result is drained. After reset all slots are free, the drop
// counter is zero and link_enabled is one.
// link_enabled is written through cfg_we and cfg_wdata and should only change
// while the block is idle.
module timed_reply_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // Configuration: link_enabled.
    input  wire         cfg_we,
    input  wire         cfg_wdata,
    // Requests.
    input  wire         s_tvalid,
    output logic        s_tready,
    // [7:0] module_id, [15:8] reply_kind, [47:16] due_ms, [79:48] now_ms
    input  wire  [79:0] s_tdata,
    // [0] func
    input  wire         s_tuser,
    // Results.
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] reply_valid, [8:1] reply_module, [16:9] reply_type,
    // [17] queue_dropped, [49:18] drop_total, [55:50] zero
    output logic [55:0] m_tdata
);
    import trq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    trq_state_t           state_reg;
    trq_state_t           state_next;
    trq_scan_t            scan_chain [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]     idx_chain  [QUEUE_DEPTH+1];
    trq_scan_t            hold_reg;
    logic [IDX_W-1:0]     hold_idx_reg;
    logic                 link_enabled_reg;
    logic [CNT_W-1:0]     drop_reg;
    logic [CNT_W-1:0]     drop_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                 accept;
    logic                 commit;
    logic                 free_en;
    logic                 is_poll;
    logic                 reply_valid;
    logic                 queue_dropped;
    logic [MOD_W-1:0]     reply_module;
    logic [KIND_W-1:0]    reply_type;
    trq_scan_t            last_scan;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The record entering the first cell; it is active only on acceptance.
    always_comb
    begin
        scan_chain[0].active    = accept;
        scan_chain[0].func      = s_tuser;
        scan_chain[0].hit       = 1'b0;
        scan_chain[0].module_id = s_tdata[7:0];
        scan_chain[0].kind      = s_tdata[15:8];
        scan_chain[0].due       = s_tdata[47:16];
        scan_chain[0].now       = s_tdata[79:48];
        idx_chain[0]            = '0;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        trq_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  (scan_chain[i]),
            .idx_in   (idx_chain[i]),
            .scan_out (scan_chain[i+1]),
            .idx_out  (idx_chain[i+1]),
            .free_en  (free_en),
            .free_idx (hold_idx_reg)
        );
    end

    assign last_scan = scan_chain[QUEUE_DEPTH];

    // The result commits once the output register is free or being drained.
    assign commit  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign is_poll = (hold_reg.func == FUNC_POLL);
    // A poll hands back and frees its slot only while the link is enabled.
    assign reply_valid   = is_poll && hold_reg.hit && link_enabled_reg;
    assign free_en       = commit && reply_valid;
    assign queue_dropped = !is_poll && !hold_reg.hit;
    assign reply_module  = reply_valid ? hold_reg.module_id : '0;
    assign reply_type    = reply_valid ? hold_reg.kind : '0;

    always_comb
    begin
        state_next     = state_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_scan.active)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    if (queue_dropped)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, drop_next, queue_dropped,
                                      reply_type, reply_module, reply_valid};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            drop_reg         <= '0;
            out_valid_reg    <= 1'b0;
            link_enabled_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                link_enabled_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (last_scan.active)
        begin
            hold_reg     <= last_scan;
            hold_idx_reg <= idx_chain[QUEUE_DEPTH];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// File: verif/tb_timed_reply_queue.sv
// Self-checking testbench for the timed reply queue: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
// The testbench drives requests into timed_reply_queue and checks every result.
// A short table of requests comes first. It covers a poll on an empty table,
// extreme field values, due times that wrap past zero, a full table with
// drops, polls and queues while the link is off, and ties on the due time.
// After the table come six random phases. Each phase has its own link setting
// and its own ratio of queue requests to polls, and starts its millisecond
// clock at a new base, some of them just short of a wrap.
// Most random requests follow a plausible timeline. Queues get due times a
// little ahead of the clock, and polls carry the current time. A share of the
// requests is noise with every field random.
// A behavioral copy of the slot table predicts each result when its request is
// accepted. Results are compared field by field in order of arrival.
module tb_timed_reply_queue;
    import trq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int N_DIRECTED    = 27;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 100;
    localparam int STALL_LIMIT   = 2000;
    // The link setting of each random phase, phase 0 in bit 0.
    localparam bit [N_PHASES-1:0] PHASE_LINK = 6'b101101;
    localparam int QUEUE_PCT [N_PHASES] = '{60, 70, 45, 75, 55, 40};

    // One result, laid out exactly as m_tdata[49:0] carries it.
    typedef struct packed {
        logic [CNT_W-1:0]  drops;
        logic              dropped;
        logic [KIND_W-1:0] rkind;
        logic [MOD_W-1:0]  rmod;
        logic              hit;
    } reply_t;

    // One request of the stimulus. When typed is set, the result is known by
    // inspection. It has no reply, and only the drop flag and count are given.
    typedef struct packed {
        logic              link;
        logic              func;
        logic [MOD_W-1:0]  mod;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
        logic              typed;
        logic              exp_dropped;
        logic [CNT_W-1:0]  exp_drops;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    timed_reply_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Shadow copy of the slot table, the drop counter and the link register.
    logic              slot_busy [DEPTH];
    logic [MOD_W-1:0]  slot_mod  [DEPTH];
    logic [KIND_W-1:0] slot_kind [DEPTH];
    logic [TIME_W-1:0] slot_due  [DEPTH];
    logic [CNT_W-1:0]  drop_count;
    logic              link_on;

    reply_t   awaited_replies [$];
    request_t directed_rows [N_DIRECTED];
    logic [TIME_W-1:0] ms_clock;

    int  errors;
    int  n_requests;
    int  n_replies;
    int  n_drops;
    int  n_quiet_polls;
    int  n_link_writes;
    bit  calm;
    bit  hold_off;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // True when a comes before b on the wrapping millisecond timeline.
    function automatic logic wraps_before(input logic [TIME_W-1:0] a,
                                          input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] gap;
        gap = a - b;
        return gap[TIME_W-1];
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic reply_t predict_reply(input request_t req);
        reply_t r;
        int     pick;
        bit     placed;
        r = '0;
        pick = -1;
        placed = 1'b0;
        if (req.func == FUNC_QUEUE) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!placed && !slot_busy[i]) begin
                    slot_busy[i] = 1'b1;
                    slot_mod[i]  = req.mod;
                    slot_kind[i] = req.kind;
                    slot_due[i]  = req.due;
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                drop_count = drop_count + 1'b1;
                r.dropped = 1'b1;
            end
        end else if (link_on) begin
            // Strictly earlier only, so the lowest slot keeps a tie.
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_busy[i] && !wraps_before(req.now, slot_due[i]) &&
                    (pick < 0 || wraps_before(slot_due[i], slot_due[pick])))
                    pick = i;
            end
            if (pick >= 0) begin
                r.hit  = 1'b1;
                r.rmod  = slot_mod[pick];
                r.rkind = slot_kind[pick];
                slot_busy[pick] = 1'b0;
            end
        end
        r.drops = drop_count;
        return r;
    endfunction

    // Offers one request, after an optional gap, and records its expected result
    // at the edge where it is accepted.
    task automatic send_request(input request_t req);
        int     gap;
        reply_t want;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req.func;
        s_tdata  <= {req.now, req.due, req.kind, req.mod};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_reply(req);
        if (req.typed) begin
            want = '0;
            want.dropped = req.exp_dropped;
            want.drops   = req.exp_drops;
        end
        awaited_replies.push_back(want);
        n_requests++;
    endtask

    // Writes the link register once the block has returned every result.
    task automatic set_link(input logic on);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(negedge clk);
        cfg_we <= 1'b0;
        link_on = on;
        n_link_writes++;
    endtask

    // Builds one random request. Most follow the phase timeline, and the rest
    // are noise with every field random.
    task automatic send_random(input int queue_pct);
        request_t req;
        req.link        = link_on;
        req.typed       = 1'b0;
        req.exp_dropped = 1'b0;
        req.exp_drops   = '0;
        req.mod         = MOD_W'($urandom);
        req.kind        = KIND_W'($urandom);
        req.due         = $urandom;
        req.now         = $urandom;
        if ($urandom_range(0, 99) < 8) begin
            req.func = 1'($urandom_range(0, 1));
        end else begin
            req.func = ($urandom_range(0, 99) < queue_pct) ? FUNC_QUEUE : FUNC_POLL;
            case ($urandom_range(0, 19))
                0:       req.due = ms_clock + 32'h7FFF_FFFF;
                1:       req.due = ms_clock - 32'h8000_0000;
                2, 3:    req.due = ms_clock;
                default: req.due = ms_clock + $urandom_range(0, 300);
            endcase
            // A poll far ahead flushes entries that sit half the range away.
            req.now = ($urandom_range(0, 15) == 0) ? ms_clock + 32'h8000_0000 : ms_clock;
            ms_clock = ms_clock + $urandom_range(0, 40);
        end
        send_request(req);
    endtask

    // The receiver idles in short random bursts. Once, on request, it holds off
    // long enough for the block to fill up and stall its input.
    initial begin
        int burst;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (burst - 1)
                    @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge clk) begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[49:0];
            if (awaited_replies.size() == 0) begin
                $error("result %h arrived with no request outstanding", m_tdata);
                errors++;
            end else begin
                want = awaited_replies.pop_front();
                if (got.hit !== want.hit) begin
                    $error("reply_valid: expected %0d, got %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.rmod !== want.rmod) begin
                    $error("reply_module: expected %0d, got %0d", want.rmod, got.rmod);
                    errors++;
                end
                if (got.rkind !== want.rkind) begin
                    $error("reply_type: expected %0d, got %0d", want.rkind, got.rkind);
                    errors++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("queue_dropped: expected %0d, got %0d",
                           want.dropped, got.dropped);
                    errors++;
                end
                if (got.drops !== want.drops) begin
                    $error("drop_total: expected %0d, got %0d", want.drops, got.drops);
                    errors++;
                end
                if (m_tdata[55:50] !== '0) begin
                    $error("padding: expected 0, got %h", m_tdata[55:50]);
                    errors++;
                end
                n_replies += want.hit;
                n_drops   += want.dropped;
            end
        end
    end

    // Watchdog: the run ends when no request or result moves for too long.
    always @(posedge clk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, awaited_replies.size());
            $display("tb_timed_reply_queue: errors");
            $finish;
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        errors    = 0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        n_requests    = 0;
        n_replies     = 0;
        n_drops       = 0;
        n_quiet_polls = 0;
        n_link_writes = 0;
        for (int i = 0; i < DEPTH; i++)
            slot_busy[i] = 1'b0;
        drop_count = '0;
        link_on    = 1'b1;

        // Columns: link, func, module, kind, due, now, typed, dropped, drop total.
        directed_rows = '{
            // A poll on the empty table after reset.
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'd0},
            // Extreme fields. The first entry is due at the very top of the range.
            '{1'b1, FUNC_QUEUE, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h00, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
            // Half the range ahead of the top entry, so only the zero entry is due.
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
            // Time zero is just past the top entry once the clock wraps.
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'd0},
            // Fill all sixteen slots. Several share due time 100.
            '{1'b1, FUNC_QUEUE, 8'h01, 8'h10, 32'd300,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h02, 8'h20, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h03, 8'h30, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h04, 8'h40, 32'h8000_0064,  32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h05, 8'h50, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h06, 8'h60, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h07, 8'h70, 32'hFFFF_FFF0,  32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h08, 8'h80, 32'd101,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h09, 8'h90, 32'd200,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0A, 8'hA0, 32'd250,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0B, 8'hB0, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0C, 8'hC0, 32'h7FFF_FFFF,  32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0D, 8'hD0, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0E, 8'hE0, 32'd400,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h0F, 8'hF0, 32'd100,        32'h0, 1'b1, 1'b0, 32'd0},
            '{1'b1, FUNC_QUEUE, 8'h10, 8'h01, 32'hC000_0000,  32'h0, 1'b1, 1'b0, 32'd0},
            // The table is full, so this queue request is dropped.
            '{1'b1, FUNC_QUEUE, 8'hAA, 8'h55, 32'd7,          32'h0, 1'b1, 1'b1, 32'd1},
            // With the link off a poll returns nothing, and a queue request is still handled.
            '{1'b0, FUNC_POLL,  8'h00, 8'h00, 32'h0,          32'd100, 1'b1, 1'b0, 32'd1},
            '{1'b0, FUNC_QUEUE, 8'h55, 8'hAA, 32'd7,          32'h0,   1'b1, 1'b1, 32'd2},
            // The wrapped entry comes first, then the ties on 100, lowest slot first.
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0,          32'd100, 1'b0, 1'b0, 32'd0},
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0,          32'd100, 1'b0, 1'b0, 32'd0},
            '{1'b1, FUNC_POLL,  8'h00, 8'h00, 32'h0,          32'd100, 1'b0, 1'b0, 32'd0}
        };

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].link != link_on)
                set_link(directed_rows[r].link);
            if (directed_rows[r].func == FUNC_POLL && !link_on)
                n_quiet_polls++;
            send_request(directed_rows[r]);
        end

        // Random phases. Each one writes the link register and moves the timeline.
        for (int p = 0; p < N_PHASES; p++) begin
            set_link(PHASE_LINK[p]);
            case (p)
                1:       ms_clock = 32'hFFFF_FF00;
                3:       ms_clock = 32'h7FFF_FF80;
                4:       ms_clock = 32'h0000_0000;
                default: ms_clock = $urandom;
            endcase
            if (p == 2)
                hold_off = 1'b1;
            if (p == N_PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_ITEMS)
                send_random(QUEUE_PCT[p]);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        // Any result the block still sends after this point is flagged by the checker.
        repeat (DEPTH + 8)
            @(posedge clk);

        $display("covered %0d requests: %0d replies returned, %0d queue requests dropped",
                 n_requests, n_replies, n_drops);
        $display("%0d link register writes, %0d directed polls with the link off",
                 n_link_writes, n_quiet_polls);
        if (errors == 0)
            $display("tb_timed_reply_queue: clean");
        else
            $display("tb_timed_reply_queue: errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/trq_pkg.sv
hw/rtl/trq_cell.sv
hw/rtl/timed_reply_queue.sv
verif/tb_timed_reply_queue.sv
